/* sv/rnsa_pkg.sv */
// ----------------------------------------------------------------------------
// rnsa_pkg
// Shared types and constants of the rotation source address generator.
// ----------------------------------------------------------------------------
package rnsa_pkg;

    // Default geometry and fixed-point format
    localparam int MAX_DIM_DEF   = 4096;
    localparam int FRAC_BITS_DEF = 14;

    // Field widths
    localparam int COORD_IN_W = 12;
    localparam int TRIG_W     = 16;
    localparam int SHIFT_W    = 28;
    localparam int DIM_REG_W  = 13;
    localparam int IDX_W      = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 28;

    // Register index codes
    localparam logic [CFG_IDX_W-1:0] REG_COS_Q14     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Q14     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_STRIDE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = 4'd7;

    // Register reset values
    localparam logic signed [TRIG_W-1:0] COS_RESET     = 16'sd16384;
    localparam logic        [DIM_REG_W-1:0] DIM_RESET  = 13'd4096;

    // Pipeline depth: multiply, sum, truncate/compare, index
    localparam int NUM_STAGES = 4;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_q14;
        logic signed [TRIG_W-1:0]  sin_q14;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic [DIM_REG_W-1:0]      img_width;
        logic [DIM_REG_W-1:0]      img_height;
        logic [DIM_REG_W-1:0]      dest_stride;
        logic [IDX_W-1:0]          dest_base;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

/* sv/rnsa_cfg.sv */
// ----------------------------------------------------------------------------
// rnsa_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rnsa_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rnsa_pkg::CFG_DATA_W-1:0] cfg_data,
    output rnsa_pkg::cfg_t              cfg
);
    import rnsa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a configuration beat
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_COS_Q14:     cfg_next.cos_q14     = signed'(cfg_data[TRIG_W-1:0]);
                REG_SIN_Q14:     cfg_next.sin_q14     = signed'(cfg_data[TRIG_W-1:0]);
                REG_SHIFT_X:     cfg_next.shift_x     = signed'(cfg_data[SHIFT_W-1:0]);
                REG_SHIFT_Y:     cfg_next.shift_y     = signed'(cfg_data[SHIFT_W-1:0]);
                REG_SRC_WIDTH:   cfg_next.img_width   = cfg_data[DIM_REG_W-1:0];
                REG_SRC_HEIGHT:  cfg_next.img_height  = cfg_data[DIM_REG_W-1:0];
                REG_DEST_STRIDE: cfg_next.dest_stride = cfg_data[DIM_REG_W-1:0];
                REG_DEST_BASE:   cfg_next.dest_base   = cfg_data[IDX_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_q14     <= COS_RESET;
            cfg_reg.sin_q14     <= '0;
            cfg_reg.shift_x     <= '0;
            cfg_reg.shift_y     <= '0;
            cfg_reg.img_width   <= DIM_RESET;
            cfg_reg.img_height  <= DIM_RESET;
            cfg_reg.dest_stride <= DIM_RESET;
            cfg_reg.dest_base   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/rnsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rnsa_ctrl
// Valid bits and load enables of the datapath stages, with stall backpressure.
// ----------------------------------------------------------------------------
module rnsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rnsa_pkg::pipe_ctrl_t ctrl
);
    import rnsa_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;
    logic [NUM_STAGES-1:0] valid_in;

    // A stage takes a beat when it is empty or its content moves on
    always_comb begin
        stage_ready[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    // Advance valid bits along with the data
    always_comb begin
        valid_in = {valid_reg[NUM_STAGES-2:0], s_valid};
        for (int k = 0; k < NUM_STAGES; k++) begin
            valid_next[k]    = stage_ready[k] ? valid_in[k] : valid_reg[k];
            ctrl.load[k]     = stage_ready[k] && valid_in[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // An accepted beat always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted beat missing from first stage");

    // An empty output stage lets the whole pipe move
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input held off with empty output stage");

    // A full pipe under stall holds every beat
    a_full_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_ready |=> (&valid_reg))
        else $error("beat lost while stalled");

endmodule

/* sv/rnsa_datapath.sv */
// ----------------------------------------------------------------------------
// rnsa_datapath
// Four-stage inverse mapping: products, sums, truncation with bounds check,
// and source index.
// ----------------------------------------------------------------------------
module rnsa_datapath #(
    parameter int MAX_DIM   = rnsa_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = rnsa_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  rnsa_pkg::pipe_ctrl_t              ctrl,
    input  rnsa_pkg::cfg_t                    cfg,
    input  logic [rnsa_pkg::COORD_IN_W-1:0]   in_row,
    input  logic [rnsa_pkg::COORD_IN_W-1:0]   in_col,
    output logic                              out_inside,
    output logic [rnsa_pkg::IDX_W-1:0]        out_src_index,
    output logic [rnsa_pkg::IDX_W-1:0]        out_dst_index
);
    import rnsa_pkg::*;

    // Product of a 12-bit coordinate and a 16-bit signed coefficient
    localparam int PROD1_W = COORD_IN_W + TRIG_W + 1;
    // Two products plus a shift term
    localparam int SUM_W   = PROD1_W + 2;
    localparam int COORD_W = SUM_W - FRAC_BITS;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int ROWS_W  = COORD_IN_W + DIM_REG_W;
    localparam int SRC_W   = 2 * DIM_W + 1;
    localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_BITS) - 1);

    // Saturated source size
    logic [DIM_W-1:0] w_sat;
    logic [DIM_W-1:0] h_sat;

    always_comb begin
        w_sat = (32'(cfg.img_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                    : DIM_W'(cfg.img_width);
        h_sat = (32'(cfg.img_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                     : DIM_W'(cfg.img_height);
    end

    // ---- Stage 1: products ----
    logic signed [PROD1_W-1:0] row_m;
    logic signed [PROD1_W-1:0] col_m;
    logic signed [PROD1_W-1:0] cos_m;
    logic signed [PROD1_W-1:0] sin_m;
    logic        [ROWS_W-1:0]  row_u;
    logic        [ROWS_W-1:0]  stride_u;

    logic signed [PROD1_W-1:0] col_cos_reg, row_sin_reg, row_cos_reg, col_sin_reg;
    logic signed [PROD1_W-1:0] col_cos_next, row_sin_next, row_cos_next, col_sin_next;
    logic [IDX_W-1:0]          row_off_reg, row_off_next;
    logic [COORD_IN_W-1:0]     col1_reg;

    always_comb begin
        row_m        = PROD1_W'(signed'({1'b0, in_row}));
        col_m        = PROD1_W'(signed'({1'b0, in_col}));
        cos_m        = PROD1_W'(cfg.cos_q14);
        sin_m        = PROD1_W'(cfg.sin_q14);
        row_u        = ROWS_W'(in_row);
        stride_u     = ROWS_W'(cfg.dest_stride);
        col_cos_next = col_m * cos_m;
        row_sin_next = row_m * sin_m;
        row_cos_next = row_m * cos_m;
        col_sin_next = col_m * sin_m;
        row_off_next = IDX_W'(row_u * stride_u);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            col_cos_reg <= col_cos_next;
            row_sin_reg <= row_sin_next;
            row_cos_reg <= row_cos_next;
            col_sin_reg <= col_sin_next;
            row_off_reg <= row_off_next;
            col1_reg    <= in_col;
        end
    end

    // ---- Stage 2: sums ----
    logic signed [SUM_W-1:0] fx_reg, fx_next;
    logic signed [SUM_W-1:0] fy_reg, fy_next;
    logic [IDX_W-1:0]        dst2_reg, dst2_next;

    always_comb begin
        fx_next   = SUM_W'(col_cos_reg) + SUM_W'(row_sin_reg) + SUM_W'(cfg.shift_x);
        fy_next   = SUM_W'(row_cos_reg) - SUM_W'(col_sin_reg) + SUM_W'(cfg.shift_y);
        dst2_next = cfg.dest_base + row_off_reg + IDX_W'(col1_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            dst2_reg <= dst2_next;
        end
    end

    // ---- Stage 3: truncate toward zero and check bounds ----
    logic [SUM_W-1:0]   fx_b;
    logic [SUM_W-1:0]   fy_b;
    logic [COORD_W-1:0] x_c;
    logic [COORD_W-1:0] y_c;
    logic               inside3_next;
    logic               inside3_reg;
    logic [DIM_W-1:0]   x3_reg;
    logic [DIM_W-1:0]   y3_reg;
    logic [IDX_W-1:0]   dst3_reg;

    always_comb begin
        // Bias negative values so the shift rounds toward zero
        fx_b = fx_reg + (fx_reg[SUM_W-1] ? TRUNC_BIAS : '0);
        fy_b = fy_reg + (fy_reg[SUM_W-1] ? TRUNC_BIAS : '0);
        x_c  = fx_b[SUM_W-1:FRAC_BITS];
        y_c  = fy_b[SUM_W-1:FRAC_BITS];
        inside3_next = !x_c[COORD_W-1] && (32'(x_c) < 32'(w_sat))
                    && !y_c[COORD_W-1] && (32'(y_c) < 32'(h_sat));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            inside3_reg <= inside3_next;
            x3_reg      <= DIM_W'(x_c);
            y3_reg      <= DIM_W'(y_c);
            dst3_reg    <= dst2_reg;
        end
    end

    // ---- Stage 4: source index ----
    logic [SRC_W-1:0] src_full;
    logic [IDX_W-1:0] src4_next;
    logic             inside4_reg;
    logic [IDX_W-1:0] src4_reg;
    logic [IDX_W-1:0] dst4_reg;

    always_comb begin
        src_full  = SRC_W'(y3_reg) * SRC_W'(w_sat) + SRC_W'(x3_reg);
        src4_next = inside3_reg ? IDX_W'(src_full) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            inside4_reg <= inside3_reg;
            src4_reg    <= src4_next;
            dst4_reg    <= dst3_reg;
        end
    end

    assign out_inside    = inside4_reg;
    assign out_src_index = src4_reg;
    assign out_dst_index = dst4_reg;

endmodule

/* sv/rotate_nearest_source_address_core.sv */
// ----------------------------------------------------------------------------
// rotate_nearest_source_address_core
// Inverse-maps destination pixel positions into a rotated source image and
// returns the source and destination pixel indexes.
//
//   Channel  Handshake           Payload
//   s_       s_valid / s_ready   s_dst_row, s_dst_col
//   m_       m_valid / m_ready   m_inside_res, m_src_index, m_dst_index
//   cfg_     cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat per cycle while m_ready does not stall; four datapath stages
// (products, sums, truncation and bounds check, source index multiply).
// Reset (aresetn low, synchronous) empties the pipe and loads register
// defaults. A stall on m_ready holds every stage that cannot move; bubbles
// still close up, so the input keeps taking beats until the pipe is full.
// Configuration writes are registered and are taken at any time.
// ----------------------------------------------------------------------------
module rotate_nearest_source_address_core #(
    parameter int MAX_DIM   = rnsa_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = rnsa_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Destination position
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rnsa_pkg::COORD_IN_W-1:0]   s_dst_row,
    input  logic [rnsa_pkg::COORD_IN_W-1:0]   s_dst_col,
    // Address result
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_inside_res,
    output logic [rnsa_pkg::IDX_W-1:0]        m_src_index,
    output logic [rnsa_pkg::IDX_W-1:0]        m_dst_index,
    // Register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rnsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rnsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rnsa_pkg::*;

    cfg_t       cfg;
    pipe_ctrl_t ctrl;

    // Register file
    rnsa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage valid bits and backpressure
    rnsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // Address arithmetic
    rnsa_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .cfg           (cfg),
        .in_row        (s_dst_row),
        .in_col        (s_dst_col),
        .out_inside    (m_inside_res),
        .out_src_index (m_src_index),
        .out_dst_index (m_dst_index)
    );

    // A fill-color result never carries a source index
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inside_res |-> m_src_index == '0)
        else $error("outside beat with nonzero source index");

endmodule
